// ----- src/ief_pkg.sv -----
// Shared types and codes for the input event frame assembler.
// Depends on nothing; imported by ief_store and input_event_frame_assembler.
`timescale 1ns / 1ps

package ief_pkg;

  localparam int unsigned FrameDepthDefault = 64;

  localparam logic [15:0] SyncType    = 16'd0;
  localparam logic [15:0] CodeReport  = 16'd0;
  localparam logic [15:0] CodeDropped = 16'd3;

  localparam logic ModeEvent = 1'b0;
  localparam logic ModeClear = 1'b1;

  localparam logic KindEvent  = 1'b0;
  localparam logic KindResync = 1'b1;

  typedef struct packed {
    logic               mode;
    logic        [15:0] ev_type;
    logic        [15:0] ev_code;
    logic signed [31:0] ev_value;
    logic        [62:0] ts_us;
  } in_t;

  typedef struct packed {
    logic               kind;
    logic        [15:0] out_type;
    logic        [15:0] out_code;
    logic signed [31:0] out_value;
    logic        [62:0] out_ts_us;
    logic               last;
    logic        [31:0] resync_total;
  } out_t;

  typedef struct packed {
    logic        [15:0] ev_type;
    logic        [15:0] ev_code;
    logic signed [31:0] ev_value;
    logic        [62:0] ts_us;
  } entry_t;

endpackage

// ----- src/ief_store.sv -----
// Pending frame store: one write port, one read port, registered read data.
// Depends on ief_pkg for the entry type.
`timescale 1ns / 1ps

module ief_store #(
  parameter int unsigned Depth = ief_pkg::FrameDepthDefault,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  ief_pkg::entry_t   wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output ief_pkg::entry_t   rdata_o
);
  import ief_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/input_event_frame_assembler.sv -----
// Input event frame assembler: ordinary accepted events are held in ief_store.
// An ordinary event is written to the store as it is accepted, unless dropping or
// full; a report with nothing pending goes from StFin to the output, otherwise the
// held events replay first, each through StRead and StLoad, bound by the store's
// single read port and its registered read data; the report or resync marker comes last.
// Reset clears control and counters; the store has no clearing pass and no valid bits.
`timescale 1ns / 1ps

module input_event_frame_assembler #(
  parameter int unsigned FRAME_DEPTH = ief_pkg::FrameDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ief_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ief_pkg::out_t out_data_o
);
  import ief_pkg::*;

  localparam int unsigned AddrW = $clog2(FRAME_DEPTH);
  localparam logic [AddrW-1:0] CntFull = AddrW'(FRAME_DEPTH - 1);
  localparam logic [AddrW-1:0] CntOne  = AddrW'(1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StLoad = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [AddrW-1:0] cnt_q, cnt_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic             drop_q, drop_d;
  logic [31:0]      rsc_q, rsc_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;
  out_t             fin_q, fin_d;

  logic   in_acc, out_free, is_sync, is_report, is_dropped;
  logic   we, re;
  entry_t wdata, rdata;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign is_sync    = (in_data_i.ev_type == SyncType);
  assign is_report  = is_sync && (in_data_i.ev_code == CodeReport);
  assign is_dropped = is_sync && (in_data_i.ev_code == CodeDropped);

  assign wdata.ev_type  = in_data_i.ev_type;
  assign wdata.ev_code  = in_data_i.ev_code;
  assign wdata.ev_value = in_data_i.ev_value;
  assign wdata.ts_us    = in_data_i.ts_us;

  ief_store #(
    .Depth(FRAME_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    drop_d      = drop_q;
    rsc_d       = rsc_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    fin_d       = fin_q;
    we          = 1'b0;
    re          = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          priority if (in_data_i.mode == ModeClear) begin
            cnt_d  = '0;
            drop_d = 1'b0;
          end else if (is_dropped) begin
            cnt_d  = '0;
            drop_d = 1'b1;
          end else if (drop_q) begin
            if (is_report) begin
              drop_d             = 1'b0;
              rsc_d              = rsc_q + 32'd1;
              fin_d.kind         = KindResync;
              fin_d.out_type     = '0;
              fin_d.out_code     = '0;
              fin_d.out_value    = '0;
              fin_d.out_ts_us    = in_data_i.ts_us;
              fin_d.last         = 1'b1;
              fin_d.resync_total = rsc_q + 32'd1;
              state_d            = StFin;
            end
          end else if (is_report) begin
            fin_d.kind         = KindEvent;
            fin_d.out_type     = in_data_i.ev_type;
            fin_d.out_code     = in_data_i.ev_code;
            fin_d.out_value    = in_data_i.ev_value;
            fin_d.out_ts_us    = in_data_i.ts_us;
            fin_d.last         = 1'b1;
            fin_d.resync_total = rsc_q;
            idx_d              = '0;
            state_d            = (cnt_q == '0) ? StFin : StRead;
          end else if (cnt_q == CntFull) begin
            cnt_d  = '0;
            drop_d = 1'b1;
          end else begin
            we    = 1'b1;
            cnt_d = cnt_q + CntOne;
          end
        end
      end
      StRead: begin
        re      = 1'b1;
        state_d = StLoad;
      end
      StLoad: begin
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_d.kind             = KindEvent;
          out_d.out_type         = rdata.ev_type;
          out_d.out_code         = rdata.ev_code;
          out_d.out_value        = rdata.ev_value;
          out_d.out_ts_us        = rdata.ts_us;
          out_d.last             = 1'b0;
          out_d.resync_total     = rsc_q;
          if (idx_q == cnt_q - CntOne) begin
            state_d = StFin;
          end else begin
            idx_d   = idx_q + CntOne;
            state_d = StRead;
          end
        end
      end
      StFin: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = fin_q;
          cnt_d       = '0;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      idx_q       <= '0;
      drop_q      <= 1'b0;
      rsc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      drop_q      <= drop_d;
      rsc_q       <= rsc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    fin_q <= fin_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_no_write_dropping: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> !drop_q)
    else $error("store written in drop mode");

  a_replay_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRead) |-> (idx_q < cnt_q))
    else $error("replay index beyond pending count");

  a_resync_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(rsc_q) |-> (rsc_q == $past(rsc_q) + 32'd1))
    else $error("resync counter moved by other than one");

  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.kind == KindResync)) |-> out_data_o.last)
    else $error("resync marker without last");

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for input_event_frame_assembler: directed frames, drops, clears
// and overflow, then random traffic under idling and back-pressure, checked per field.
// Depends on ief_pkg and input_event_frame_assembler.
`timescale 1ns / 1ps

module tb_top;
  import ief_pkg::*;

  localparam int FrameDepth = FrameDepthDefault;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  entry_t frame_store[FrameDepth];
  int frame_fill = 0;
  bit in_drop = 1'b0;
  logic [31:0] resync_count = '0;
  out_t expected_results[$];

  int errors = 0;
  int sent_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  input_event_frame_assembler #(
    .FRAME_DEPTH(FrameDepth)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic queue_result(input out_t res);
    expected_results.insert(expected_results.size(), res);
  endtask

  task automatic predict_frame(input in_t req);
    out_t res;
    bit is_report;
    bit is_dropped;
    is_report = req.ev_type == SyncType && req.ev_code == CodeReport;
    is_dropped = req.ev_type == SyncType && req.ev_code == CodeDropped;
    res = '0;
    if (req.mode == ModeClear) begin
      frame_fill = 0;
      in_drop = 1'b0;
    end else if (is_dropped) begin
      frame_fill = 0;
      in_drop = 1'b1;
    end else if (in_drop) begin
      if (is_report) begin
        in_drop = 1'b0;
        resync_count = resync_count + 32'd1;
        res.kind = KindResync;
        res.out_ts_us = req.ts_us;
        res.last = 1'b1;
        res.resync_total = resync_count;
        queue_result(res);
      end
    end else if (is_report) begin
      for (int i = 0; i < frame_fill; i++) begin
        res.kind = KindEvent;
        res.out_type = frame_store[i].ev_type;
        res.out_code = frame_store[i].ev_code;
        res.out_value = frame_store[i].ev_value;
        res.out_ts_us = frame_store[i].ts_us;
        res.last = 1'b0;
        res.resync_total = resync_count;
        queue_result(res);
      end
      res.kind = KindEvent;
      res.out_type = req.ev_type;
      res.out_code = req.ev_code;
      res.out_value = req.ev_value;
      res.out_ts_us = req.ts_us;
      res.last = 1'b1;
      res.resync_total = resync_count;
      queue_result(res);
      frame_fill = 0;
    end else if (frame_fill >= FrameDepth - 1) begin
      frame_fill = 0;
      in_drop = 1'b1;
    end else begin
      frame_store[frame_fill] = '{req.ev_type, req.ev_code, req.ev_value, req.ts_us};
      frame_fill++;
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= $urandom_range(99) >= stall_pct;
    end
  end

  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0h", $time, out_data_o);
      end else begin
        want = expected_results.pop_front();
        check_field("kind", 64'(want.kind), 64'(out_data_o.kind));
        check_field("out_type", 64'(want.out_type), 64'(out_data_o.out_type));
        check_field("out_code", 64'(want.out_code), 64'(out_data_o.out_code));
        check_field("out_value", 64'(want.out_value), 64'(out_data_o.out_value));
        check_field("out_ts_us", 64'(want.out_ts_us), 64'(out_data_o.out_ts_us));
        check_field("last", 64'(want.last), 64'(out_data_o.last));
        check_field("resync_total", 64'(want.resync_total),
                    64'(out_data_o.resync_total));
      end
    end
  end

  function automatic logic [62:0] rand_ts();
    return 63'({$urandom, $urandom});
  endfunction

  function automatic in_t make_item(logic mode, logic [15:0] ev_type, logic [15:0] ev_code,
                                    logic [31:0] ev_value, logic [62:0] ts_us);
    in_t req;
    req.mode = mode;
    req.ev_type = ev_type;
    req.ev_code = ev_code;
    req.ev_value = ev_value;
    req.ts_us = ts_us;
    return req;
  endfunction

  // Any event that neither reports nor drops; sync type with other codes included.
  function automatic in_t rand_event();
    logic [15:0] ev_type;
    logic [15:0] ev_code;
    ev_type = ($urandom_range(7) == 0) ? SyncType : 16'($urandom);
    ev_code = ($urandom_range(3) == 0) ? 16'($urandom_range(1, 2)) : 16'($urandom);
    if (ev_type == SyncType && (ev_code == CodeReport || ev_code == CodeDropped))
      ev_code = 16'h8000;
    return make_item(ModeEvent, ev_type, ev_code, $urandom, rand_ts());
  endfunction

  task automatic send_request(input in_t req);
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (!in_ready_o);
    predict_frame(req);
    sent_count++;
  endtask

  task automatic send_events(input int count);
    repeat (count) send_request(rand_event());
  endtask

  task automatic send_report();
    send_request(make_item(ModeEvent, SyncType, CodeReport, $urandom, rand_ts()));
  endtask

  task automatic send_dropped();
    send_request(make_item(ModeEvent, SyncType, CodeDropped, $urandom, rand_ts()));
  endtask

  task automatic send_clear();
    send_request(make_item(ModeClear, 16'($urandom), 16'($urandom), $urandom, rand_ts()));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic test_field_extremes();
    send_request(make_item(ModeEvent, 16'hffff, 16'hffff, 32'h8000_0000, '1));
    send_request(make_item(ModeEvent, 16'h0001, 16'h0000, 32'h7fff_ffff, '0));
    send_request(make_item(ModeEvent, SyncType, 16'h0001, 32'hffff_ffff, 63'h1));
    send_request(make_item(ModeEvent, SyncType, 16'hffff, 32'h0, rand_ts()));
    send_request(make_item(ModeEvent, SyncType, CodeReport, 32'h8000_0000, '1));
    send_request(make_item(ModeEvent, SyncType, CodeReport, 32'h0, '0));
    wait_drained();
  endtask

  task automatic test_sync_dropped();
    send_events(3);
    send_dropped();
    send_events(2);
    send_dropped();
    send_request(make_item(ModeEvent, SyncType, CodeReport, 32'h7fff_ffff, '1));
    send_events(1);
    send_report();
    wait_drained();
  endtask

  task automatic test_clear();
    send_events(2);
    send_clear();
    send_report();
    send_dropped();
    send_request(make_item(ModeClear, SyncType, CodeDropped, $urandom, rand_ts()));
    send_events(1);
    send_report();
    wait_drained();
  endtask

  task automatic test_full_frame();
    send_events(FrameDepth - 1);
    send_report();
    wait_drained();
  endtask

  task automatic test_frame_overflow();
    send_events(FrameDepth);
    send_events(2);
    send_report();
    send_events(FrameDepth - 2);
    send_report();
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_left = 400;
    repeat (4) begin
      send_events(12);
      send_report();
    end
    wait_drained();
  endtask

  task automatic test_drain_pause();
    send_events(5);
    send_report();
    wait_drained();
    send_dropped();
    send_report();
    wait_drained();
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct, input int busy_pct);
    int target;
    int pick;
    send_idle_pct = idle_pct;
    stall_pct = busy_pct;
    target = sent_count + count;
    while (sent_count < target) begin
      pick = $urandom_range(99);
      if (pick < 68) begin
        send_events(($urandom_range(11) == 0) ? $urandom_range(10, FrameDepth - 1)
                                              : $urandom_range(6));
        send_report();
      end else if (pick < 80) begin
        send_events($urandom_range(4));
        send_dropped();
        send_events($urandom_range(3));
        send_report();
      end else if (pick < 88) begin
        send_events($urandom_range(3));
        send_clear();
      end else if (pick < 90) begin
        send_events(FrameDepth + $urandom_range(2));
        send_report();
      end else begin
        send_request(make_item(ModeEvent, 16'($urandom_range(1) ? 0 : $urandom),
                               16'($urandom_range(4)), $urandom, rand_ts()));
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_field_extremes();
    test_sync_dropped();
    test_clear();
    test_full_frame();
    test_frame_overflow();
    test_backpressure();
    test_drain_pause();
    test_random_traffic(20, 0, 0);
    test_random_traffic(20, 45, 0);
    test_random_traffic(20, 0, 45);
    test_random_traffic(20, 33, 33);
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- input_event_frame_assembler.f -----
src/ief_pkg.sv
src/ief_store.sv
src/input_event_frame_assembler.sv
dv/tb_top.sv
